>>> rtl/hcbd_pkg.sv
// Package for the HTTP chunked body decoder: payload structs, widths,
// character codes and stop reasons. No dependencies.
package hcbd_pkg;

  localparam int SIZE_BITS = 64;
  localparam int LEN_BITS  = 32;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;

  localparam logic [1:0] REASON_NONE    = 2'd0;
  localparam logic [1:0] REASON_ZERO    = 2'd1;
  localparam logic [1:0] REASON_NODIGIT = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } hcbd_in_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                out_valid;
    logic                done_res;
    logic [1:0]          end_reason;
    logic [LEN_BITS-1:0] total_len;
  } hcbd_out_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.hit   = 1'b1;
    h.value = 4'd0;
    if (c inside {[CH_0 : CH_9]}) begin
      h.value = 4'(c - CH_0);
    end else if (c inside {[CH_LC_A : CH_LC_F]}) begin
      h.value = 4'(c - CH_LC_A + 8'd10);
    end else if (c inside {[CH_UC_A : CH_UC_F]}) begin
      h.value = 4'(c - CH_UC_A + 8'd10);
    end else begin
      h.hit = 1'b0;
    end
    return h;
  endfunction

endpackage

>>> rtl/http_chunked_body_decoder.sv
// HTTP chunked body decoder: passes payload bytes of a chunked body on and
// reports the stop reason and length on the last byte. Uses hcbd_pkg.
// A byte is held in the input register, and its result then in the output
// register. Throughput: one byte per cycle while the output is not stalled;
// the phase logic between the input and result registers updates the state.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to the start of a size line; the state also returns there after
// the transaction that carries a last byte.
module http_chunked_body_decoder
  import hcbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  hcbd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output hcbd_out_t out_data
);

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_DIGITS = 3'd1;
  localparam logic [2:0] PH_CR     = 3'd2;
  localparam logic [2:0] PH_LF     = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_TCR    = 3'd5;
  localparam logic [2:0] PH_TLF    = 3'd6;
  localparam logic [2:0] PH_STOP   = 3'd7;

  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  logic                 s1_v_r;
  hcbd_in_t             s1_r;
  logic [2:0]           phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] count_r, count_nxt;
  logic [LEN_BITS-1:0]  total_r, total_nxt;
  logic [1:0]           stop_r, stop_nxt;
  logic                 ov_r;
  hcbd_out_t            out_r;

  logic       out_free, s1_go, emit, has_res, fall;
  logic [2:0] cur;
  logic [1:0] reason;
  hex_t       hx;

  assign out_free = !ov_r || !out_stall;
  assign s1_go    = s1_v_r && out_free;
  assign in_stall = s1_v_r && !out_free;
  assign hx       = hex_decode(s1_r.in_byte);

  // The optional CR/LF phases fall through to the next phase when the byte
  // does not match, so one byte may pass through several phases.
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    total_nxt = total_r;
    stop_nxt  = stop_r;
    emit      = 1'b0;
    cur       = phase_r;
    fall      = 1'b1;
    if (cur == PH_STOP) begin
      fall = 1'b0;
    end
    if (cur == PH_DIGITS) begin
      fall = 1'b0;
      if (hx.hit) begin
        count_nxt = {count_r[SIZE_BITS-5:0], hx.value};
      end else if (count_r == '0) begin
        stop_nxt  = REASON_ZERO;
        phase_nxt = PH_STOP;
      end else begin
        phase_nxt = (s1_r.in_byte == CH_CR) ? PH_LF : PH_CR;
      end
    end
    if (fall && cur == PH_CR) begin
      if (s1_r.in_byte == CH_CR) begin
        phase_nxt = PH_LF;
        fall      = 1'b0;
      end else begin
        cur = PH_LF;
      end
    end
    if (fall && cur == PH_LF) begin
      if (s1_r.in_byte == CH_LF) begin
        phase_nxt = PH_DATA;
        fall      = 1'b0;
      end else begin
        cur = PH_DATA;
      end
    end
    if (fall && cur == PH_DATA) begin
      if (count_r == '0) begin
        cur = PH_TCR;
      end else begin
        fall      = 1'b0;
        emit      = 1'b1;
        count_nxt = count_r - SIZE_BITS'(1);
        if (total_r != LEN_MAX) begin
          total_nxt = total_r + LEN_BITS'(1);
        end
        phase_nxt = (count_r == SIZE_BITS'(1)) ? PH_TCR : PH_DATA;
      end
    end
    if (fall && cur == PH_TCR) begin
      if (s1_r.in_byte == CH_CR) begin
        phase_nxt = PH_TLF;
        fall      = 1'b0;
      end else begin
        cur = PH_TLF;
      end
    end
    if (fall && cur == PH_TLF) begin
      if (s1_r.in_byte == CH_LF) begin
        phase_nxt = PH_START;
        fall      = 1'b0;
      end else begin
        cur = PH_START;
      end
    end
    if (fall && cur == PH_START) begin
      if (hx.hit) begin
        count_nxt = SIZE_BITS'(hx.value);
        phase_nxt = PH_DIGITS;
      end else begin
        stop_nxt  = REASON_NODIGIT;
        phase_nxt = PH_STOP;
      end
    end
  end

  // A body that ends inside a size line of zeros counts as a zero-size chunk.
  always_comb begin
    reason = REASON_NONE;
    if (s1_r.last) begin
      reason = stop_nxt;
      if (stop_nxt == REASON_NONE && phase_nxt == PH_DIGITS && count_nxt == '0) begin
        reason = REASON_ZERO;
      end
    end
  end

  assign has_res = emit || s1_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      ov_r    <= 1'b0;
      phase_r <= PH_START;
      count_r <= '0;
      total_r <= '0;
      stop_r  <= REASON_NONE;
    end else begin
      if (!in_stall) begin
        s1_v_r <= in_valid;
      end
      if (s1_go && has_res) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
      if (s1_go) begin
        if (s1_r.last) begin
          phase_r <= PH_START;
          count_r <= '0;
          total_r <= '0;
          stop_r  <= REASON_NONE;
        end else begin
          phase_r <= phase_nxt;
          count_r <= count_nxt;
          total_r <= total_nxt;
          stop_r  <= stop_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_r <= in_data;
    end
    if (s1_go && has_res) begin
      out_r.out_byte   <= emit ? s1_r.in_byte : 8'd0;
      out_r.out_valid  <= emit;
      out_r.done_res   <= s1_r.last;
      out_r.end_reason <= reason;
      out_r.total_len  <= total_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

  a_reason_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.end_reason != REASON_NONE |-> out_data.done_res)
    else $error("stop reason reported on a result that is not the last");

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.done_res |-> out_data.out_valid)
    else $error("result with neither a payload byte nor a last marker");

  a_stop_has_reason: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_STOP |-> stop_r != REASON_NONE)
    else $error("parser stopped without a reason");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r && ov_r && out_stall)
    else $error("input stalled while the pipeline could advance");

endmodule
